// File: rtl/core/dwrc_pkg.sv
package dwrc_pkg;

  // Geometry and screen constants
  localparam int MAP_DIM   = 32;
  localparam int SCREEN_W  = 640;
  localparam int SCREEN_H  = 480;
  localparam int TEX_W     = 64;

  localparam int MAP_CELLS = MAP_DIM * MAP_DIM;
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int MAP_IDX_W = $clog2(MAP_DIM);
  // Map coordinate: room for the 5 integer bits of the position, a sign and one step past the edge
  localparam int COORD_W   = ((MAP_IDX_W > 5) ? MAP_IDX_W : 5) + 2;

  localparam logic [7:0] EMPTY_CELL = 8'd46;

  localparam int POS_W      = 21;
  localparam int VEC_W      = 18;
  localparam int CAM_W      = 18;
  localparam int RAY_W      = 20;
  localparam int DIST_W     = 52;
  localparam int DIV_NW     = 33;
  localparam int DIV_DW     = 25;
  localparam int MUL_AW     = 34;
  localparam int MUL_BW     = 20;
  localparam int PROD_W     = MUL_AW + MUL_BW;
  localparam int HGT_W      = 15;
  localparam int ROW_W      = 14;
  localparam int TEXC_W     = 6;
  localparam int PERP_W     = 24;
  localparam int COL_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // Camera x by reciprocal multiply: |2*col - SCREEN_W| * 2^16 / SCREEN_W, exact floor
  localparam int CAM_K  = 17 + 2 * $clog2(SCREEN_W);
  localparam int CAM_SH = CAM_K - 16;
  localparam int CAM_RW = CAM_K - $clog2(SCREEN_W) + 1;
  localparam int CAM_PW = CAM_RW + 11;
  localparam logic [CAM_RW-1:0] CAM_RECIP =
    CAM_RW'(((64'd1 << CAM_K) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W));

  localparam logic [DIST_W-1:0] SAT_DIST = DIST_W'(1) << 44;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_NONE    = 3'd0,
    MUL_PLANE_X = 3'd1,
    MUL_PLANE_Y = 3'd2,
    MUL_SIDE_X  = 3'd3,
    MUL_SIDE_Y  = 3'd4,
    MUL_WALL    = 3'd5
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_DX  = 2'd0,
    DIV_DY  = 2'd1,
    DIV_HGT = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    div_sel_e div_sel;
    mul_sel_e mul_sel;
    logic     ld_rx;
    logic     ld_ry;
    logic     ld_dx;
    logic     ld_dy;
    logic     ld_sdx;
    logic     ld_sdy;
    logic     step;
    logic     look;
    logic     ld_perp;
    logic     ld_tex;
    logic     ld_hgt;
    logic     ld_out;
  } dwrc_cmd_t;

  typedef struct packed {
    logic cast_ok;
    logic div_done;
    logic outside;
    logic is_wall;
    logic out_free;
  } dwrc_sts_t;

endpackage

// File: rtl/core/dwrc_div.sv
module dwrc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dwrc_pkg::DIV_NW-1:0]  num_i,
  input  logic [dwrc_pkg::DIV_DW-1:0]  den_i,
  output logic                         done_o,
  output logic [dwrc_pkg::DIV_NW-1:0]  quot_o
);
  import dwrc_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_NW-1:0] quot_q;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem_q, quot_q[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_NW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      den_q  <= den_i;
      quot_q <= num_i;
    end else if (busy_q) begin
      rem_q  <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
      quot_q <= {quot_q[DIV_NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: rtl/core/dwrc_ctrl.sv
module dwrc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dwrc_pkg::dwrc_sts_t sts_i,
  output dwrc_pkg::dwrc_cmd_t cmd_o
);
  import dwrc_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_RX_M   = 18'h00002,
    S_RY_M   = 18'h00004,
    S_RY     = 18'h00008,
    S_DX     = 18'h00010,
    S_DX_WT  = 18'h00020,
    S_DY     = 18'h00040,
    S_DY_WT  = 18'h00080,
    S_SDX_M  = 18'h00100,
    S_SDY_M  = 18'h00200,
    S_SDY    = 18'h00400,
    S_STEP   = 18'h00800,
    S_LOOK   = 18'h01000,
    S_PERP   = 18'h02000,
    S_WALL_M = 18'h04000,
    S_TEX    = 18'h08000,
    S_HGT_WT = 18'h10000,
    S_DONE   = 18'h20000
  } state_e;

  state_e    state_q, state_d;
  dwrc_cmd_t cmd;

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_DX;
    cmd.mul_sel = MUL_NONE;
    state_d     = state_q;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd.accept = in_valid_i;
        if (in_valid_i && sts_i.cast_ok) state_d = S_RX_M;
      end
      S_RX_M: begin
        cmd.mul_sel = MUL_PLANE_X;
        state_d     = S_RY_M;
      end
      S_RY_M: begin
        cmd.mul_sel = MUL_PLANE_Y;
        cmd.ld_rx   = 1'b1;
        state_d     = S_RY;
      end
      S_RY: begin
        cmd.ld_ry = 1'b1;
        state_d   = S_DX;
      end
      S_DX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DX;
        state_d       = S_DX_WT;
      end
      S_DX_WT: begin
        if (sts_i.div_done) begin
          cmd.ld_dx = 1'b1;
          state_d   = S_DY;
        end
      end
      S_DY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DY;
        state_d       = S_DY_WT;
      end
      S_DY_WT: begin
        if (sts_i.div_done) begin
          cmd.ld_dy = 1'b1;
          state_d   = S_SDX_M;
        end
      end
      S_SDX_M: begin
        cmd.mul_sel = MUL_SIDE_X;
        state_d     = S_SDY_M;
      end
      S_SDY_M: begin
        cmd.mul_sel = MUL_SIDE_Y;
        cmd.ld_sdx  = 1'b1;
        state_d     = S_SDY;
      end
      S_SDY: begin
        cmd.ld_sdy = 1'b1;
        state_d    = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        state_d  = S_LOOK;
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        state_d  = (sts_i.outside || sts_i.is_wall) ? S_PERP : S_STEP;
      end
      S_PERP: begin
        cmd.ld_perp = 1'b1;
        state_d     = S_WALL_M;
      end
      S_WALL_M: begin
        cmd.mul_sel   = MUL_WALL;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_HGT;
        state_d       = S_TEX;
      end
      S_TEX: begin
        cmd.ld_tex = 1'b1;
        state_d    = S_HGT_WT;
      end
      S_HGT_WT: begin
        if (sts_i.div_done) begin
          cmd.ld_hgt = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd.ld_out = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

endmodule

// File: rtl/core/dwrc_dp.sv
module dwrc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dwrc_pkg::dwrc_cmd_t                 cmd_i,
  output dwrc_pkg::dwrc_sts_t                 sts_o,
  input  logic                                req_type_i,
  input  logic [dwrc_pkg::COL_W-1:0]          column_i,
  input  logic [9:0]                          cell_index_i,
  input  logic [7:0]                          cell_value_i,
  input  logic                                cfg_valid_i,
  input  logic [dwrc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dwrc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dwrc_pkg::COL_W-1:0]          out_column_o,
  output logic [7:0]                          wall_kind_o,
  output logic                                wall_side_o,
  output logic [dwrc_pkg::TEXC_W-1:0]         tex_column_o,
  output logic [dwrc_pkg::PERP_W-1:0]         perp_distance_o,
  output logic signed [dwrc_pkg::ROW_W-1:0]   draw_start_o,
  output logic signed [dwrc_pkg::ROW_W-1:0]   draw_end_o,
  output logic                                left_map_o
);
  import dwrc_pkg::*;

  localparam logic signed [COORD_W-1:0] MAP_DIM_S = COORD_W'(MAP_DIM);

  function automatic logic signed [ROW_W-1:0] clamp_row(input logic signed [16:0] v);
    logic signed [ROW_W-1:0] r;
    if (v > 17'sd8191) r = 14'sd8191;
    else if (v < -17'sd8192) r = -14'sd8192;
    else r = v[ROW_W-1:0];
    return r;
  endfunction

  // Camera registers
  logic        [POS_W-1:0] pos_x_q, pos_y_q;
  logic signed [VEC_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      dir_x_q   <= -18'sd65536;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= 18'sd43254;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_POS_X:   pos_x_q   <= cfg_data_i;
        CFG_POS_Y:   pos_y_q   <= cfg_data_i;
        CFG_DIR_X:   dir_x_q   <= cfg_data_i[VEC_W-1:0];
        CFG_DIR_Y:   dir_y_q   <= cfg_data_i[VEC_W-1:0];
        CFG_PLANE_X: plane_x_q <= cfg_data_i[VEC_W-1:0];
        CFG_PLANE_Y: plane_y_q <= cfg_data_i[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Request decode
  logic              col_ok, idx_ok;
  logic signed [11:0] cdiff;
  logic        [11:0] cmag;
  logic [CAM_PW-1:0]  cam_prod;
  logic signed [CAM_W-1:0] cam_mag;

  assign col_ok   = {1'b0, column_i} < 11'(SCREEN_W);
  assign idx_ok   = {22'd0, cell_index_i} < 32'(MAP_CELLS);
  assign cdiff    = $signed({1'b0, column_i, 1'b0}) - $signed(12'(SCREEN_W));
  assign cmag     = cdiff[11] ? 12'(-cdiff) : 12'(cdiff);
  assign cam_prod = CAM_PW'(cmag[10:0]) * CAM_PW'(CAM_RECIP);
  assign cam_mag  = $signed(cam_prod[CAM_SH +: CAM_W]);

  logic [COL_W-1:0]        column_q;
  logic signed [CAM_W-1:0] cam_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !req_type_i && col_ok) begin
      column_q <= column_i;
      cam_q    <= cdiff[11] ? -cam_mag : cam_mag;
    end
  end

  // Shared divider
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] quot;

  logic signed [RAY_W-1:0] rx_q, ry_q;
  logic        [RAY_W-1:0] rx_mag, ry_mag;
  logic [DIST_W-1:0]       perp_q;

  assign rx_mag = rx_q[RAY_W-1] ? RAY_W'(-rx_q) : RAY_W'(rx_q);
  assign ry_mag = ry_q[RAY_W-1] ? RAY_W'(-ry_q) : RAY_W'(ry_q);

  always_comb begin
    case (cmd_i.div_sel)
      DIV_DX: begin
        div_num = DIV_NW'(1) << 32;
        div_den = DIV_DW'(rx_mag);
      end
      DIV_DY: begin
        div_num = DIV_NW'(1) << 32;
        div_den = DIV_DW'(ry_mag);
      end
      DIV_HGT: begin
        div_num = DIV_NW'(SCREEN_H) << 16;
        div_den = perp_q[DIV_DW-1:0];
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  dwrc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Shared multiplier, product registered
  logic        [DIST_W-1:0] dx_q, dy_q, sdx_q, sdy_q;
  logic        [16:0]       frac_x, frac_y;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic                     side_q;

  assign frac_x  = rx_q[RAY_W-1] ? {1'b0, pos_x_q[15:0]} : 17'h10000 - {1'b0, pos_x_q[15:0]};
  assign frac_y  = ry_q[RAY_W-1] ? {1'b0, pos_y_q[15:0]} : 17'h10000 - {1'b0, pos_y_q[15:0]};

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_PLANE_X: begin
        mul_a = MUL_AW'(plane_x_q);
        mul_b = MUL_BW'(cam_q);
      end
      MUL_PLANE_Y: begin
        mul_a = MUL_AW'(plane_y_q);
        mul_b = MUL_BW'(cam_q);
      end
      MUL_SIDE_X: begin
        mul_a = $signed({1'b0, dx_q[DIV_NW-1:0]});
        mul_b = $signed({3'b0, frac_x});
      end
      MUL_SIDE_Y: begin
        mul_a = $signed({1'b0, dy_q[DIV_NW-1:0]});
        mul_b = $signed({3'b0, frac_y});
      end
      MUL_WALL: begin
        // Only the low 32 product bits feed the texture fraction
        mul_a = $signed({2'b0, perp_q[31:0]});
        mul_b = side_q ? rx_q : ry_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Ray setup
  logic rx_zero, ry_zero;
  assign rx_zero = rx_q == '0;
  assign ry_zero = ry_q == '0;

  logic signed [COORD_W-1:0] mx_q, my_q, nmx, nmy;
  logic                      lt, in_map;
  logic [ADDR_W-1:0]         addr;
  logic                      outside_q;
  logic [7:0]                rd_q;
  logic [7:0]                mem [MAP_CELLS];

  assign lt     = sdx_q < sdy_q;
  assign nmx    = lt ? (rx_q[RAY_W-1] ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
  assign nmy    = lt ? my_q : (ry_q[RAY_W-1] ? my_q - 1'b1 : my_q + 1'b1);
  assign in_map = !nmx[COORD_W-1] && (nmx < MAP_DIM_S) && !nmy[COORD_W-1] && (nmy < MAP_DIM_S);
  assign addr   = ADDR_W'($unsigned(nmy)) * ADDR_W'(MAP_DIM) + ADDR_W'($unsigned(nmx));

  // Map memory: write on a cell transfer, read one cell per walk step that stays in the map
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && req_type_i && idx_ok) begin
      mem[ADDR_W'(cell_index_i)] <= cell_value_i;
    end
    if (cmd_i.step && in_map) begin
      rd_q <= mem[addr];
    end
  end

  logic [7:0] kind_q;
  logic       left_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_rx)  rx_q <= RAY_W'(dir_x_q) + RAY_W'(prod_q >>> 16);
    if (cmd_i.ld_ry)  ry_q <= RAY_W'(dir_y_q) + RAY_W'(prod_q >>> 16);
    if (cmd_i.ld_dx)  dx_q <= rx_zero ? SAT_DIST : DIST_W'(quot);
    if (cmd_i.ld_dy)  dy_q <= ry_zero ? SAT_DIST : DIST_W'(quot);
    if (cmd_i.ld_sdx) begin
      sdx_q <= rx_zero ? SAT_DIST : DIST_W'(prod_q[PROD_W-1:16]);
      mx_q  <= COORD_W'(pos_x_q[POS_W-1:16]);
    end
    if (cmd_i.ld_sdy) begin
      sdy_q <= ry_zero ? SAT_DIST : DIST_W'(prod_q[PROD_W-1:16]);
      my_q  <= COORD_W'(pos_y_q[POS_W-1:16]);
    end
    if (cmd_i.step) begin
      if (lt) sdx_q <= sdx_q + dx_q;
      else    sdy_q <= sdy_q + dy_q;
      mx_q      <= nmx;
      my_q      <= nmy;
      side_q    <= !lt;
      outside_q <= !in_map;
    end
    if (cmd_i.look) begin
      kind_q <= outside_q ? 8'd0 : rd_q;
      left_q <= outside_q;
    end
    if (cmd_i.ld_perp) perp_q <= side_q ? sdy_q - dy_q : sdx_q - dx_q;
  end

  assign sts_o.cast_ok  = !req_type_i && col_ok;
  assign sts_o.div_done = div_done;
  assign sts_o.outside  = outside_q;
  assign sts_o.is_wall  = rd_q != EMPTY_CELL;

  // Texture column
  logic [15:0] fr;
  logic [26:0] tex_prod;
  logic [10:0] tex_raw, tex_sel;
  logic        mirror;
  logic [TEXC_W-1:0] tex_q;

  assign fr       = (side_q ? pos_x_q[15:0] : pos_y_q[15:0]) + prod_q[31:16];
  assign tex_prod = 27'(fr) * 27'(TEX_W);
  assign tex_raw  = tex_prod[26:16];
  assign mirror   = (!side_q && !rx_q[RAY_W-1] && !rx_zero) || (side_q && ry_q[RAY_W-1]);
  assign tex_sel  = mirror ? 11'(TEX_W - 1) - tex_raw : tex_raw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_tex) tex_q <= tex_sel[TEXC_W-1:0];
  end

  // Strip height and limits
  logic [HGT_W-1:0]       hgt;
  logic [ROW_W-1:0]       half;
  logic signed [16:0]     ds_w, de_w;
  logic signed [ROW_W-1:0] ds_q, de_q;

  always_comb begin
    if (perp_q == '0) hgt = '1;
    else if (|perp_q[DIST_W-1:DIV_DW]) hgt = '0;
    else if (|quot[DIV_NW-1:HGT_W]) hgt = '1;
    else hgt = quot[HGT_W-1:0];
  end

  assign half = hgt[HGT_W-1:1];
  assign ds_w = $signed(17'(SCREEN_H / 2)) - $signed({3'b0, half});
  assign de_w = $signed(17'(SCREEN_H / 2)) + $signed({3'b0, half});

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_hgt) begin
      ds_q <= clamp_row(ds_w);
      de_q <= clamp_row(de_w);
    end
  end

  // Output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_out) begin
      out_column_o    <= column_q;
      wall_kind_o     <= kind_q;
      wall_side_o     <= side_q;
      tex_column_o    <= tex_q;
      perp_distance_o <= (|perp_q[DIST_W-1:PERP_W]) ? '1 : perp_q[PERP_W-1:0];
      draw_start_o    <= ds_q;
      draw_end_o      <= de_q;
      left_map_o      <= left_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

// File: rtl/core/dda_wall_ray_caster.sv
// Channel   Handshake                Payload
// in        in_valid_i / in_ready_o  req_type_i, column_i, cell_index_i, cell_value_i
// out       out_valid_o / out_ready_i out_column_o, wall_kind_o, wall_side_o, tex_column_o,
//                                    perp_distance_o, draw_start_o, draw_end_o, left_map_o
// cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A cell write or a dropped cast is taken in the idle state. Camera x comes from a reciprocal
// multiply at the input transfer. A cast then takes three runs of the shared radix-2
// divider, each with its issue state (two step distances, strip height), plus the states
// of accept, ray setup, perpendicular distance and output load, then, for each grid cell
// walked, a memory read state and a check state.
// Reset clears the controller and the output valid flag and presets the camera registers;
// map cells hold nothing until written. The result sits in an output register, so a
// stalled out transfer holds only the next cast's final load, not its input transfer.
module dda_wall_ray_caster (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [dwrc_pkg::COL_W-1:0]          column_i,
  input  logic [9:0]                          cell_index_i,
  input  logic [7:0]                          cell_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dwrc_pkg::COL_W-1:0]          out_column_o,
  output logic [7:0]                          wall_kind_o,
  output logic                                wall_side_o,
  output logic [dwrc_pkg::TEXC_W-1:0]         tex_column_o,
  output logic [dwrc_pkg::PERP_W-1:0]         perp_distance_o,
  output logic signed [dwrc_pkg::ROW_W-1:0]   draw_start_o,
  output logic signed [dwrc_pkg::ROW_W-1:0]   draw_end_o,
  output logic                                left_map_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dwrc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dwrc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import dwrc_pkg::*;

  dwrc_cmd_t cmd;
  dwrc_sts_t sts;

  // Camera registers take a transfer on any cycle
  assign cfg_ready_o = 1'b1;

  // Sequence the cast: setup divisions, grid walk, strip finish
  dwrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Map memory, camera registers, divider, multiplier and result register
  dwrc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .column_i        (column_i),
    .cell_index_i    (cell_index_i),
    .cell_value_i    (cell_value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_column_o    (out_column_o),
    .wall_kind_o     (wall_kind_o),
    .wall_side_o     (wall_side_o),
    .tex_column_o    (tex_column_o),
    .perp_distance_o (perp_distance_o),
    .draw_start_o    (draw_start_o),
    .draw_end_o      (draw_end_o),
    .left_map_o      (left_map_o)
  );

endmodule
